// ===== hdl/angle_frame_crc_check_convert_unit_assert.svh =====
// assertion macros for the angle frame checker, used by the acfc_frame module
// needs a clock and a synchronous active-high reset in the including module
`ifndef ANGLE_FRAME_CRC_CHECK_CONVERT_UNIT_ASSERT_SVH
`define ANGLE_FRAME_CRC_CHECK_CONVERT_UNIT_ASSERT_SVH

// same-cycle implication
`define ACFC_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("acfc same-cycle check failed");

// next-cycle implication
`define ACFC_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("acfc next-cycle check failed");

`endif

// ===== hdl/acfc_pkg.sv =====
// types, constants and crc-8 functions for the angle frame checker
// no dependencies
package acfc_pkg;

  localparam logic [7:0]  CRC_POLY  = 8'h1D;
  localparam logic [7:0]  CRC_INIT  = 8'hFF;
  localparam logic [15:0] CMD_RESET = 16'h8021;
  localparam logic [19:0] Q20_MUL   = 20'd823550;
  localparam int          Q20_SHIFT = 12;
  localparam int          PROD_W    = 35;

  localparam logic [1:0] IDX_DATA_HIGH = 2'd0;
  localparam logic [1:0] IDX_DATA_LOW  = 2'd1;
  localparam logic [1:0] IDX_SAFETY    = 2'd2;
  localparam logic [1:0] IDX_CRC       = 2'd3;

  typedef struct packed {
    logic [14:0] angle;
    logic        ok;
    logic        fresh;
  } frame_result_t;

  function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] c;
    c = crc ^ b;
    for (int k = 0; k < 8; k++) begin
      if (c[7]) begin
        c = {c[6:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[6:0], 1'b0};
      end
    end
    return c;
  endfunction

  function automatic logic [7:0] crc8_cmd(input logic [15:0] w);
    return crc8_byte(crc8_byte(CRC_INIT, w[15:8]), w[7:0]);
  endfunction

  localparam logic [7:0] CMD_CRC_RESET = crc8_cmd(CMD_RESET);

endpackage

// ===== hdl/acfc_in_reg.sv =====
// input register stage for received response bytes
// depends on nothing but the port handshake
module acfc_in_reg (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] rx_byte,
  input  logic       frame_start,
  output logic       s1_valid,
  output logic [7:0] s1_byte,
  output logic       s1_start,
  input  logic       s1_ready
);

  assign in_ready = !s1_valid || s1_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_byte  <= rx_byte;
      s1_start <= frame_start;
    end
  end

endmodule

// ===== hdl/acfc_frame.sv =====
// frame tracking, crc-8 update and check, held angle and result register
// depends on acfc_pkg and the assertion macro header
`include "angle_frame_crc_check_convert_unit_assert.svh"

module acfc_frame
  import acfc_pkg::*;
(
  input  logic          clk,
  input  logic          rst,
  input  logic          cfg_write,
  input  logic [15:0]   cfg_data,
  input  logic          s1_valid,
  input  logic [7:0]    s1_byte,
  input  logic          s1_start,
  output logic          s1_ready,
  output logic          res_valid,
  output frame_result_t res,
  input  logic          res_ready
);

  logic [7:0]  cmd_crc;
  logic [7:0]  crc_reg;
  logic [1:0]  byte_index;
  logic [15:0] data_word;
  logic [14:0] held_angle;

  logic [1:0]  idx;
  logic        produce;
  logic        adv;
  logic [7:0]  crc_next;
  logic        crc_match;
  logic [14:0] angle_next;

  assign idx        = s1_start ? IDX_DATA_HIGH : byte_index;
  assign produce    = (idx == IDX_CRC);
  assign s1_ready   = !produce || !res_valid || res_ready;
  assign adv        = s1_valid && s1_ready;
  assign crc_next   = crc8_byte((idx == IDX_DATA_HIGH) ? cmd_crc : crc_reg, s1_byte);
  assign crc_match  = (~crc_reg == s1_byte);
  assign angle_next = crc_match ? data_word[14:0] : held_angle;

  // the user must change command bytes only while idle, which the block leaves unenforced; their crc is kept ready
  always_ff @(posedge clk) begin
    if (rst) begin
      cmd_crc <= CMD_CRC_RESET;
    end else if (cfg_write) begin
      cmd_crc <= crc8_cmd(cfg_data);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      crc_reg    <= CRC_INIT;
      byte_index <= IDX_DATA_HIGH;
      data_word  <= '0;
      held_angle <= '0;
    end else if (adv) begin
      byte_index <= idx + 2'd1;
      unique case (idx)
        IDX_DATA_HIGH: begin
          crc_reg         <= crc_next;
          data_word[15:8] <= s1_byte;
        end
        IDX_DATA_LOW: begin
          crc_reg        <= crc_next;
          data_word[7:0] <= s1_byte;
        end
        IDX_SAFETY: begin
        end
        IDX_CRC: begin
          held_angle <= angle_next;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (adv && produce) begin
      res_valid <= 1'b1;
    end else if (res_ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && produce) begin
      res.angle <= angle_next;
      res.ok    <= crc_match;
      res.fresh <= data_word[15];
    end
  end

  `ACFC_ASSERT_NEXT(a_result_on_crc_byte, clk, rst, adv && produce, res_valid)
  `ACFC_ASSERT_NEXT(a_fail_holds_angle, clk, rst, adv && produce && !crc_match,
                    res.angle == $past(held_angle) && !res.ok)
  `ACFC_ASSERT_NEXT(a_start_restarts, clk, rst, adv && s1_start, byte_index == IDX_DATA_LOW)
  `ACFC_ASSERT_NOW(a_stall_only_on_busy_result, clk, rst, s1_valid && !s1_ready,
                   res_valid && !res_ready)

endmodule

// ===== hdl/acfc_convert.sv =====
// radian conversion and output register
// depends on acfc_pkg
module acfc_convert
  import acfc_pkg::*;
(
  input  logic          clk,
  input  logic          rst,
  input  logic          res_valid,
  input  frame_result_t res,
  output logic          res_ready,
  output logic          out_valid,
  input  logic          out_ready,
  output logic [14:0]   angle_raw,
  output logic [22:0]   angle_q20,
  output logic          crc_ok,
  output logic          fresh_flag
);

  logic [PROD_W-1:0] prod;

  assign prod      = PROD_W'(res.angle) * PROD_W'(Q20_MUL);
  assign res_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_ready) begin
      out_valid <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      angle_raw  <= res.angle;
      angle_q20  <= prod[PROD_W-1:Q20_SHIFT];
      crc_ok     <= res.ok;
      fresh_flag <= res.fresh;
    end
  end

endmodule

// ===== hdl/angle_frame_crc_check_convert_unit.sv =====
// Angle frame checker: takes the four response bytes of a sensor angle read
// (data high, data low, safety, crc), one per transfer, checks a CRC-8
// (poly 0x1D, init 0xFF, final inversion) over the two command bytes and data
// bytes, and on the crc byte delivers one result with the 15-bit angle, its
// radian value in unsigned Q.20, crc_ok and the fresh flag. On a crc failure
// the last good angle is repeated. One byte is accepted every cycle unless
// back-pressure from the output stalls it; the crc byte of a result passes from
// the input register through the crc check register, then the multiply and
// output register. frame_start restarts a frame.
module angle_frame_crc_check_convert_unit
  import acfc_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_write,
  input  logic [15:0] cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  rx_byte,
  input  logic        frame_start,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [14:0] angle_raw,
  output logic [22:0] angle_q20,
  output logic        crc_ok,
  output logic        fresh_flag
);

  logic          s1_valid;
  logic [7:0]    s1_byte;
  logic          s1_start;
  logic          s1_ready;
  logic          res_valid;
  frame_result_t res;
  logic          res_ready;

  acfc_in_reg u_in_reg (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .rx_byte     (rx_byte),
    .frame_start (frame_start),
    .s1_valid    (s1_valid),
    .s1_byte     (s1_byte),
    .s1_start    (s1_start),
    .s1_ready    (s1_ready)
  );

  acfc_frame u_frame (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_data  (cfg_data),
    .s1_valid  (s1_valid),
    .s1_byte   (s1_byte),
    .s1_start  (s1_start),
    .s1_ready  (s1_ready),
    .res_valid (res_valid),
    .res       (res),
    .res_ready (res_ready)
  );

  acfc_convert u_convert (
    .clk        (clk),
    .rst        (rst),
    .res_valid  (res_valid),
    .res        (res),
    .res_ready  (res_ready),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .angle_raw  (angle_raw),
    .angle_q20  (angle_q20),
    .crc_ok     (crc_ok),
    .fresh_flag (fresh_flag)
  );

endmodule

// ===== dv/tb.sv =====
// testbench for angle_frame_crc_check_convert_unit: a table of directed frames, then
// random well-formed, broken and noisy byte streams under random idling on both sides
// depends on acfc_pkg and the unit; results checked against a crc-8 and q20 predictor
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import acfc_pkg::*;

  localparam int WATCH_LIMIT   = 3000;
  localparam int HOLD_CYCLES   = 400;
  localparam int SETTLE_CYCLES = 8;
  localparam int PHASE_ITEMS   = 222;
  localparam int PHASES        = 6;

  typedef struct packed {
    logic [14:0] angle;
    logic [22:0] q20;
    logic        ok;
    logic        fresh;
  } angle_result_t;

  typedef enum logic [1:0] {ROW_DATA, ROW_GOOD_CRC, ROW_BAD_CRC, ROW_CMD} row_kind_t;
  typedef enum logic [1:0] {RX_ALWAYS, RX_MOSTLY, RX_SPARSE, RX_PATTERN} rx_mode_t;

  typedef struct {
    row_kind_t     kind;
    logic [15:0]   value;
    logic          start;
    logic          fixed;
    angle_result_t result;
  } stim_row_t;

  logic          clk         = 1'b0;
  logic          rst         = 1'b1;
  logic          cfg_write   = 1'b0;
  logic [15:0]   cfg_data    = '0;
  logic          in_valid    = 1'b0;
  logic          in_ready;
  logic [7:0]    rx_byte     = '0;
  logic          frame_start = 1'b0;
  logic          out_valid;
  logic          out_ready   = 1'b0;
  logic [14:0]   angle_raw;
  logic [22:0]   angle_q20;
  logic          crc_ok;
  logic          fresh_flag;

  // typed expectation riding along with the payload
  logic          tag_fixed   = 1'b0;
  angle_result_t tag_result  = '0;

  // predictor state
  logic [15:0]   sh_cmd;
  logic [7:0]    run_crc;
  logic [1:0]    next_slot;
  logic [15:0]   rx_word;
  logic [14:0]   kept_angle;
  angle_result_t due_angles[$];
  int            fails = 0;

  // sender state
  logic [15:0]   cmd_now   = CMD_RESET;
  logic [15:0]   drv_cmd   = CMD_RESET;
  logic [1:0]    drv_slot  = IDX_DATA_HIGH;
  logic [7:0]    drv_hi    = '0;
  logic [7:0]    drv_lo    = '0;
  int            burst_left = 0;
  int            burst_max  = 4;
  int            gap_max    = 3;
  int            sent       = 0;

  // receiver state
  rx_mode_t      rx_mode   = RX_MOSTLY;
  int            hold_ask  = 0;
  int            hold_seen = 0;
  int            hold_left = 0;
  logic [2:0]    rx_tick   = '0;
  int            quiet     = 0;

  angle_frame_crc_check_convert_unit uut (
    .clk        (clk),
    .rst        (rst),
    .cfg_write  (cfg_write),
    .cfg_data   (cfg_data),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .rx_byte    (rx_byte),
    .frame_start(frame_start),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .angle_raw  (angle_raw),
    .angle_q20  (angle_q20),
    .crc_ok     (crc_ok),
    .fresh_flag (fresh_flag)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic logic [7:0] crc8_next(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] c;
    c = crc ^ b;
    repeat (8) c = c[7] ? ({c[6:0], 1'b0} ^ CRC_POLY) : {c[6:0], 1'b0};
    return c;
  endfunction

  function automatic logic [22:0] rad_q20(input logic [14:0] a);
    logic [37:0] p;
    p = 38'(a) * 38'(Q20_MUL);
    return p[Q20_SHIFT +: 23];
  endfunction

  function automatic bit absorb_byte(input logic [7:0] b, input logic st,
                                     output angle_result_t res);
    logic [1:0] slot;
    bit         got;
    slot = st ? IDX_DATA_HIGH : next_slot;
    got  = 1'b0;
    res  = '0;
    case (slot)
      IDX_DATA_HIGH: begin
        run_crc = crc8_next(crc8_next(crc8_next(CRC_INIT, sh_cmd[15:8]), sh_cmd[7:0]), b);
        rx_word[15:8] = b;
      end
      IDX_DATA_LOW: begin
        run_crc = crc8_next(run_crc, b);
        rx_word[7:0] = b;
      end
      IDX_SAFETY: begin
      end
      default: begin
        res.ok = ((~run_crc) == b);
        if (res.ok) kept_angle = rx_word[14:0];
        res.angle = kept_angle;
        res.q20   = rad_q20(kept_angle);
        res.fresh = rx_word[15];
        got = 1'b1;
      end
    endcase
    next_slot = slot + 2'd1;
    return got;
  endfunction

  function automatic angle_result_t angle_res(input logic [14:0] a, input logic [22:0] q,
                                              input logic ok, input logic fr);
    angle_result_t r;
    r.angle = a;
    r.q20   = q;
    r.ok    = ok;
    r.fresh = fr;
    return r;
  endfunction

  function automatic stim_row_t mk_row(input row_kind_t k, input logic [15:0] v,
                                       input logic st, input logic fix,
                                       input angle_result_t r);
    stim_row_t row;
    row.kind   = k;
    row.value  = v;
    row.start  = st;
    row.fixed  = fix;
    row.result = r;
    return row;
  endfunction

  function automatic logic [7:0] pick_byte();
    case ($urandom_range(0, 7))
      0: return 8'h00;
      1: return 8'hFF;
      default: return 8'($urandom);
    endcase
  endfunction

  // input side: predict on every transfer, follow register writes
  always @(posedge clk) begin
    angle_result_t r;
    bit            got;
    if (rst) begin
      sh_cmd     = CMD_RESET;
      run_crc    = CRC_INIT;
      next_slot  = IDX_DATA_HIGH;
      rx_word    = '0;
      kept_angle = '0;
    end else begin
      if (cfg_write) sh_cmd = cfg_data;
      if (in_valid && in_ready) begin
        got = absorb_byte(rx_byte, frame_start, r);
        if (got) due_angles.push_back(tag_fixed ? tag_result : r);
      end
    end
  end

  // output side
  always @(posedge clk) begin
    angle_result_t want;
    if (!rst && out_valid && out_ready) begin
      if (due_angles.size() == 0) begin
        $error("unexpected transfer: angle_raw %0d crc_ok %0d", angle_raw, crc_ok);
        fails++;
      end else begin
        want = due_angles.pop_front();
        if (angle_raw !== want.angle) begin
          $error("angle_raw expected %0d got %0d", want.angle, angle_raw);
          fails++;
        end
        if (angle_q20 !== want.q20) begin
          $error("angle_q20 expected %0d got %0d", want.q20, angle_q20);
          fails++;
        end
        if (crc_ok !== want.ok) begin
          $error("crc_ok expected %0d got %0d", want.ok, crc_ok);
          fails++;
        end
        if (fresh_flag !== want.fresh) begin
          $error("fresh_flag expected %0d got %0d", want.fresh, fresh_flag);
          fails++;
        end
      end
    end
  end

  // receiver stall pattern, with a long hold-off on request
  always @(posedge clk) begin
    rx_tick <= rx_tick + 3'd1;
    if (hold_ask != hold_seen) begin
      hold_seen <= hold_ask;
      hold_left <= HOLD_CYCLES;
      out_ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else begin
      case (rx_mode)
        RX_ALWAYS: out_ready <= 1'b1;
        RX_MOSTLY: out_ready <= ($urandom_range(0, 3) != 0);
        RX_SPARSE: out_ready <= ($urandom_range(0, 3) == 0);
        default:   out_ready <= (rx_tick < 3'd3);
      endcase
    end
  end

  always @(posedge clk) begin
    if (rst || cfg_write || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet <= 0;
    end else if (quiet >= WATCH_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  task automatic put_byte(input logic [7:0] b, input logic st, input logic fix,
                          input angle_result_t fx);
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, gap_max);
      burst_left = $urandom_range(1, burst_max);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    in_valid    <= 1'b1;
    rx_byte     <= b;
    frame_start <= st;
    tag_fixed   <= fix;
    tag_result  <= fx;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    burst_left--;
    sent++;
    if (st) drv_slot = IDX_DATA_HIGH;
    if (drv_slot == IDX_DATA_HIGH) begin
      drv_hi  = b;
      drv_cmd = cmd_now;
    end
    if (drv_slot == IDX_DATA_LOW) drv_lo = b;
    drv_slot = drv_slot + 2'd1;
  endtask

  task automatic put_crc(input bit good, input logic fix, input angle_result_t fx);
    logic [7:0] c;
    c = ~crc8_next(crc8_next(crc8_next(crc8_next(CRC_INIT, drv_cmd[15:8]), drv_cmd[7:0]),
                             drv_hi), drv_lo);
    if (!good) c = c ^ 8'($urandom_range(1, 255));
    put_byte(c, 1'b0, fix, fx);
  endtask

  // wait for every result, then let the pipeline empty
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (due_angles.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    burst_left = 0;
  endtask

  task automatic write_cmd(input logic [15:0] v);
    cfg_write <= 1'b1;
    cfg_data  <= v;
    @(posedge clk);
    cfg_write <= 1'b0;
    cmd_now = v;
  endtask

  task automatic send_frame();
    int            pick;
    int            len;
    angle_result_t none;
    none = '0;
    pick = $urandom_range(0, 99);
    if (pick < 72) begin
      put_byte(pick_byte(), (drv_slot != IDX_DATA_HIGH) || ($urandom_range(0, 7) != 0),
               1'b0, none);
      put_byte(pick_byte(), 1'b0, 1'b0, none);
      put_byte(8'($urandom), 1'b0, 1'b0, none);
      put_crc($urandom_range(0, 3) != 0, 1'b0, none);
    end else if (pick < 86) begin
      len = $urandom_range(1, 3);
      put_byte(pick_byte(), 1'b1, 1'b0, none);
      repeat (len - 1) put_byte(pick_byte(), 1'b0, 1'b0, none);
    end else begin
      len = $urandom_range(1, 5);
      repeat (len) put_byte(8'($urandom), 1'($urandom), 1'b0, none);
    end
    if ($urandom_range(0, 79) == 0) settle();
  endtask

  initial begin
    stim_row_t     plan[$];
    angle_result_t none;
    logic [15:0]   phase_cmd;
    none = '0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // bad crc right after reset gives the zero angle
    plan.push_back(mk_row(ROW_DATA, 16'hFF, 1'b1, 1'b0, none));
    plan.push_back(mk_row(ROW_DATA, 16'hFF, 1'b0, 1'b0, none));
    plan.push_back(mk_row(ROW_DATA, 16'h00, 1'b0, 1'b0, none));
    plan.push_back(mk_row(ROW_BAD_CRC, 16'h0, 1'b0, 1'b1, angle_res(15'd0, 23'd0, 1'b0, 1'b1)));
    // largest angle
    plan.push_back(mk_row(ROW_DATA, 16'h7F, 1'b1, 1'b0, none));
    plan.push_back(mk_row(ROW_DATA, 16'hFF, 1'b0, 1'b0, none));
    plan.push_back(mk_row(ROW_DATA, 16'hAA, 1'b0, 1'b0, none));
    plan.push_back(mk_row(ROW_GOOD_CRC, 16'h0, 1'b0, 1'b1,
                          angle_res(15'h7FFF, 23'd6588198, 1'b1, 1'b0)));
    // bad crc holds the last good angle
    plan.push_back(mk_row(ROW_DATA, 16'h80, 1'b1, 1'b0, none));
    plan.push_back(mk_row(ROW_DATA, 16'h00, 1'b0, 1'b0, none));
    plan.push_back(mk_row(ROW_DATA, 16'h55, 1'b0, 1'b0, none));
    plan.push_back(mk_row(ROW_BAD_CRC, 16'h0, 1'b0, 1'b1,
                          angle_res(15'h7FFF, 23'd6588198, 1'b0, 1'b1)));
    // start mark mid-frame restarts
    plan.push_back(mk_row(ROW_DATA, 16'h12, 1'b1, 1'b0, none));
    plan.push_back(mk_row(ROW_DATA, 16'h34, 1'b0, 1'b0, none));
    plan.push_back(mk_row(ROW_DATA, 16'h00, 1'b1, 1'b0, none));
    plan.push_back(mk_row(ROW_DATA, 16'h01, 1'b0, 1'b0, none));
    plan.push_back(mk_row(ROW_DATA, 16'h33, 1'b0, 1'b0, none));
    plan.push_back(mk_row(ROW_GOOD_CRC, 16'h0, 1'b0, 1'b1, angle_res(15'd1, 23'd201, 1'b1, 1'b0)));
    // no start mark after a complete frame
    plan.push_back(mk_row(ROW_DATA, 16'h80, 1'b0, 1'b0, none));
    plan.push_back(mk_row(ROW_DATA, 16'h00, 1'b0, 1'b0, none));
    plan.push_back(mk_row(ROW_DATA, 16'hFF, 1'b0, 1'b0, none));
    plan.push_back(mk_row(ROW_GOOD_CRC, 16'h0, 1'b0, 1'b1, angle_res(15'd0, 23'd0, 1'b1, 1'b1)));
    // command change after byte 0 does not touch this frame
    plan.push_back(mk_row(ROW_DATA, 16'h7F, 1'b1, 1'b0, none));
    plan.push_back(mk_row(ROW_CMD, 16'h0000, 1'b0, 1'b0, none));
    plan.push_back(mk_row(ROW_DATA, 16'hFF, 1'b0, 1'b0, none));
    plan.push_back(mk_row(ROW_DATA, 16'h00, 1'b0, 1'b0, none));
    plan.push_back(mk_row(ROW_GOOD_CRC, 16'h0, 1'b0, 1'b1,
                          angle_res(15'h7FFF, 23'd6588198, 1'b1, 1'b0)));

    foreach (plan[i]) begin
      case (plan[i].kind)
        ROW_CMD: begin
          settle();
          write_cmd(plan[i].value);
        end
        ROW_GOOD_CRC: put_crc(1'b1, plan[i].fixed, plan[i].result);
        ROW_BAD_CRC:  put_crc(1'b0, plan[i].fixed, plan[i].result);
        default:      put_byte(plan[i].value[7:0], plan[i].start, plan[i].fixed, plan[i].result);
      endcase
    end
    settle();

    for (int p = 0; p < PHASES; p++) begin
      case (p)
        0: phase_cmd = 16'h0000;
        1: phase_cmd = 16'hFFFF;
        2: phase_cmd = CMD_RESET;
        default: phase_cmd = 16'($urandom);
      endcase
      write_cmd(phase_cmd);
      rx_mode   = (p == 0) ? RX_ALWAYS : rx_mode_t'(p % 4);
      burst_max = (p < 2) ? 64 : $urandom_range(2, 24);
      gap_max   = (p < 2) ? 0 : $urandom_range(1, 8);
      if (p == 3) hold_ask++;
      sent = 0;
      while (sent < PHASE_ITEMS) send_frame();
      // sometimes leave a frame open across the command write
      if ($urandom_range(0, 2) == 0) put_byte(pick_byte(), 1'b1, 1'b0, none);
      settle();
    end

    if (fails == 0) $display("Regression PASS");
    else $display("Regression FAIL");
    $finish;
  end

endmodule
